// ===== sv/icbt_pkg.sv =====
// Shared types and constants of the IPv4 CIDR block table.
package icbt_pkg;

   // Table depth and derived widths
   localparam int MAX_RANGES = 16;
   localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   // Fixed field widths
   localparam int ADDR_W        = 32;
   localparam int PLEN_W        = 6;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   // Longest legal prefix length
   localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(32);

   // Opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PREFIX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

   // Request payload
   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] prefix_len;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     blocked;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic insert;
      logic scan_start;
      logic scan_step;
      logic hit_set;
   } icbt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_lookup;
      logic empty;
      logic hit;
      logic last;
   } icbt_stat_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESP
   } icbt_state_type;

endpackage

// ===== sv/ipv4_cidr_block_table.sv =====
// Top level of the IPv4 CIDR block table.
//
// Usage:
//   A request (req_data: opcode, address, prefix_len) is taken at a rising
//   edge with start high and busy low. An insert masks the address with the
//   netmask of prefix_len and appends the range; a lookup reports blocked
//   when any stored range contains the address.
//   Each request gives one response on rsp_data, marked by rsp_valid for a
//   single cycle; the receiver cannot stall and must take it then.
//   An insert, or a lookup on an empty table, goes from S_EXEC straight to
//   S_RESP; any other lookup scans in S_SCAN between the two. The scan reads
//   one range per cycle from the range memory, stopping at the first hit or
//   the last stored range. busy falls in the cycle after rsp_valid.
//   Reset clears the entry count and the controller; the table is empty and
//   a request may be given in the first cycle after reset.
module ipv4_cidr_block_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  icbt_pkg::req_type req_data,
   output logic              rsp_valid,
   output icbt_pkg::rsp_type rsp_data
);

   icbt_pkg::icbt_cmd_type  cmd;
   icbt_pkg::icbt_stat_type stat;

   icbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   icbt_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // An accepted request keeps the block busy until its response
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   // A response only appears while a request is in progress
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response without a request in progress");

   // A rejected insert never reports a hit
   a_reject_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != icbt_pkg::STATUS_OK) |-> !rsp_data.blocked)
      else $error("rejected insert reports blocked");

   // Entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <=
         icbt_pkg::ENTRY_COUNT_W'(icbt_pkg::MAX_RANGES)))
      else $error("entry count beyond table depth");

endmodule

// ===== sv/icbt_dp.sv =====
// Datapath of the CIDR block table: request register, range memory, scan compare.
module icbt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  icbt_pkg::req_type      req_data,
   input  icbt_pkg::icbt_cmd_type cmd,
   output icbt_pkg::icbt_stat_type stat,
   output icbt_pkg::rsp_type      rsp_data
);

   // Netmask from a prefix length of 0 to 32
   function automatic logic [icbt_pkg::ADDR_W-1:0] prefix_mask(
      input logic [icbt_pkg::PLEN_W-1:0] plen
   );
      logic [icbt_pkg::ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> plen);
   endfunction

   // Range memory: network and mask per entry
   logic [icbt_pkg::ADDR_W-1:0] net_mem  [icbt_pkg::MAX_RANGES];
   logic [icbt_pkg::ADDR_W-1:0] mask_mem [icbt_pkg::MAX_RANGES];

   icbt_pkg::req_type           req_ff;
   logic [icbt_pkg::CNT_W-1:0]  count_ff;
   logic [icbt_pkg::CNT_W-1:0]  scan_idx_ff;
   logic [icbt_pkg::CNT_W-1:0]  scan_idx_in;
   logic [icbt_pkg::ADDR_W-1:0] rd_net_ff;
   logic [icbt_pkg::ADDR_W-1:0] rd_mask_ff;
   logic                        pend_ff;
   logic                        last_ff;
   logic [icbt_pkg::STATUS_W-1:0] status_ff;
   logic                        hit_ff;
   logic [icbt_pkg::ADDR_W-1:0] new_mask;
   logic                        bad_prefix;
   logic                        full;
   logic                        match;

   assign new_mask   = prefix_mask(req_ff.prefix_len);
   assign bad_prefix = (req_ff.prefix_len > icbt_pkg::MAX_PREFIX);
   assign full       = (count_ff >= icbt_pkg::CNT_W'(icbt_pkg::MAX_RANGES));
   assign match      = ((req_ff.address & rd_mask_ff) == rd_net_ff);
   assign scan_idx_in = scan_idx_ff + icbt_pkg::CNT_W'(1);

   // Request register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Memory write on an accepted insert
   always_ff @(posedge clock) begin
      if (cmd.insert && !bad_prefix && !full) begin
         net_mem[count_ff[icbt_pkg::IDX_W-1:0]]  <= req_ff.address & new_mask;
         mask_mem[count_ff[icbt_pkg::IDX_W-1:0]] <= new_mask;
      end
   end

   // Memory read for the scan, one entry a cycle while scan_step is high
   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_net_ff  <= net_mem[scan_idx_ff[icbt_pkg::IDX_W-1:0]];
         rd_mask_ff <= mask_mem[scan_idx_ff[icbt_pkg::IDX_W-1:0]];
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert && !bad_prefix && !full) begin
         count_ff <= count_ff + icbt_pkg::CNT_W'(1);
      end
   end

   // Scan index and read-pending flag
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_in;
         pend_ff     <= 1'b1;
         last_ff     <= (scan_idx_ff == count_ff - icbt_pkg::CNT_W'(1));
      end
   end

   // Result fields
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         hit_ff <= 1'b0;
         priority if (bad_prefix) begin
            status_ff <= icbt_pkg::STATUS_BAD_PREFIX;
         end else if (full) begin
            status_ff <= icbt_pkg::STATUS_FULL;
         end else begin
            status_ff <= icbt_pkg::STATUS_OK;
         end
      end else if (cmd.scan_start) begin
         hit_ff    <= 1'b0;
         status_ff <= icbt_pkg::STATUS_OK;
      end else if (cmd.hit_set) begin
         hit_ff <= 1'b1;
      end
   end

   // Status to the controller
   assign stat.is_lookup = (req_ff.opcode == icbt_pkg::OP_LOOKUP);
   assign stat.empty     = (count_ff == '0);
   assign stat.hit       = pend_ff && match;
   assign stat.last      = pend_ff && last_ff;

   assign rsp_data.status      = status_ff;
   assign rsp_data.blocked     = hit_ff;
   assign rsp_data.entry_count = icbt_pkg::ENTRY_COUNT_W'(count_ff);

endmodule

// ===== sv/icbt_ctrl.sv =====
// Controller state machine of the CIDR block table.
module icbt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  icbt_pkg::icbt_stat_type stat,
   output icbt_pkg::icbt_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   icbt_pkg::icbt_state_type state_ff;
   icbt_pkg::icbt_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icbt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         icbt_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = icbt_pkg::S_EXEC;
            end
         end
         icbt_pkg::S_EXEC: begin
            if (!stat.is_lookup) begin
               cmd.insert = 1'b1;
               state_in   = icbt_pkg::S_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = stat.empty ? icbt_pkg::S_RESP : icbt_pkg::S_SCAN;
            end
         end
         icbt_pkg::S_SCAN: begin
            // compare the entry read last cycle, fetch the next one
            priority if (stat.hit) begin
               cmd.hit_set = 1'b1;
               state_in    = icbt_pkg::S_RESP;
            end else if (stat.last) begin
               state_in = icbt_pkg::S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         icbt_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = icbt_pkg::S_IDLE;
         end
         default: begin
            state_in = icbt_pkg::S_IDLE;
         end
      endcase
   end

endmodule
